### design/hpc_pkg.sv
// Shared types and constants for the heartbeat pixel color block.
package hpc_pkg;

   // Field widths
   localparam int LED_COUNT_W = 11;
   localparam int PIXEL_W     = 10;
   localparam int TIME_W      = 32;
   localparam int COLOR_W     = 24;
   localparam int RATE_W      = 16;
   localparam int FLOOR_W     = 9;
   localparam int RADIATE_W   = 16;
   localparam int CHAN_W      = 8;
   localparam int PHASE_W     = 16;
   localparam int DIST_W      = 17;
   localparam int ENV_W       = 17;
   localparam int NUM_W       = LED_COUNT_W + 1;
   localparam int DIV_STEPS   = 17;

   // Configuration port
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [2:0] {
      REG_BASE_COLOR    = 3'd0,
      REG_BEAT_RATE     = 3'd1,
      REG_FLOOR_LEVEL   = 3'd2,
      REG_RADIATE_DELAY = 3'd3,
      REG_LED_COUNT     = 3'd4
   } reg_index_type;

   // Register reset values
   localparam logic [COLOR_W-1:0]     BASE_COLOR_RST    = 24'hff0000;
   localparam logic [RATE_W-1:0]      BEAT_RATE_RST     = 16'd512;
   localparam logic [FLOOR_W-1:0]     FLOOR_LEVEL_RST   = 9'd41;
   localparam logic [RADIATE_W-1:0]   RADIATE_DELAY_RST = 16'd7864;
   localparam logic [LED_COUNT_W-1:0] LED_COUNT_RST     = 11'd1024;

   // Pulse shape constants (Q0.16)
   localparam longint unsigned LUB_CENTER = 64'd3277;
   localparam longint unsigned DUB_CENTER = 64'd17695;
   localparam longint unsigned LUB_DEN    = 64'd2 * 64'd3604 * 64'd3604;
   localparam longint unsigned DUB_DEN    = 64'd2 * 64'd3932 * 64'd3932;
   localparam longint unsigned DUB_SCALE  = 64'd42598;
   localparam longint unsigned ONE_Q30    = 64'd1 << 30;
   localparam logic [FLOOR_W-1:0] FULL_SCALE = 9'd256;

   // One step of the distance divider
   typedef struct packed {
      logic                   valid;
      logic [NUM_W-1:0]       rem;
      logic [DIV_STEPS-1:0]   quo;
      logic [LED_COUNT_W-1:0] den;
      logic                   zero;
      logic                   sat;
      logic [PHASE_W-1:0]     beat;
   } div_stage_type;

endpackage

### design/hpc_req_if.sv
// Request channel interface: pixel index and time stamp.
interface hpc_req_if;
   logic                             valid;
   logic                             ready;
   logic [hpc_pkg::PIXEL_W-1:0]      pixel_index;
   logic [hpc_pkg::TIME_W-1:0]       time_ticks;

   modport source (output valid, output pixel_index, output time_ticks, input ready);
   modport sink   (input valid, input pixel_index, input time_ticks, output ready);
endinterface

### design/hpc_rsp_if.sv
// Response channel interface: pixel RGB.
interface hpc_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [hpc_pkg::CHAN_W-1:0]  red;
   logic [hpc_pkg::CHAN_W-1:0]  green;
   logic [hpc_pkg::CHAN_W-1:0]  blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

### design/heartbeat_pixel_color_top.sv
// Heartbeat pixel color pipeline with APB-style register port.
//
// Takes one request per cycle while the response side does not stall, and
// returns one RGB response per request, in order. The pipeline has 23
// register stages: an entry stage (strip geometry and beat multiply), 17
// distance divider stages (one quotient bit per stage), then the delay
// multiply, table index, pulse table read, level and color stages. The whole
// pipeline holds while a finished response waits to be taken. Registers may
// be written only while no request is in flight.
module heartbeat_pixel_color_top #(
   parameter int MAX_LEDS          = 1024,
   parameter int PULSE_TABLE_DEPTH = 256
) (
   input  logic                              clock,
   input  logic                              reset,
   hpc_req_if.sink                           req_ch,
   hpc_rsp_if.source                         rsp_ch,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [hpc_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [hpc_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [hpc_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);

   localparam int KW         = (PULSE_TABLE_DEPTH > 1) ? $clog2(PULSE_TABLE_DEPTH) : 1;
   localparam int TABLE_BITS = PULSE_TABLE_DEPTH * hpc_pkg::ENV_W;
   localparam int LED_CAP    = (MAX_LEDS > 2047) ? 2047 : MAX_LEDS;
   localparam logic [hpc_pkg::LED_COUNT_W-1:0] LED_CAP_C =
      hpc_pkg::LED_COUNT_W'(LED_CAP);
   localparam logic [KW:0] DEPTH_C = (KW+1)'(PULSE_TABLE_DEPTH);

   // Pulse table build, worked out at elaboration
   function automatic logic [hpc_pkg::ENV_W-1:0] neg_exp(longint unsigned u);
      longint unsigned v, v2, v3, e;
      if (u >= (64'd20 << 16)) return '0;
      v  = u << 6;
      v2 = (v * v) >> 30;
      v3 = (v2 * v) >> 30;
      e  = hpc_pkg::ONE_Q30 - v + (v2 >> 1) - v3 / 64'd6;
      for (int i = 0; i < 8; i++) e = (e * e) >> 30;
      return e[30:14];
   endfunction

   function automatic longint unsigned wrap_dist(longint unsigned p, longint unsigned c);
      longint unsigned d;
      d = (p - c) & 64'hFFFF;
      if (d > 64'd32768) d = 64'd65536 - d;
      return d * d;
   endfunction

   function automatic logic [TABLE_BITS-1:0] build_rom();
      logic [TABLE_BITS-1:0] rom;
      longint unsigned p, lub, dub;
      rom = '0;
      for (int k = 0; k < PULSE_TABLE_DEPTH; k++) begin
         p   = (longint'(k) * 64'd65536) / PULSE_TABLE_DEPTH;
         lub = 64'(neg_exp((wrap_dist(p, hpc_pkg::LUB_CENTER) << 16) / hpc_pkg::LUB_DEN));
         dub = 64'(neg_exp((wrap_dist(p, hpc_pkg::DUB_CENTER) << 16) / hpc_pkg::DUB_DEN));
         dub = (dub * hpc_pkg::DUB_SCALE) >> 16;
         rom[k*hpc_pkg::ENV_W +: hpc_pkg::ENV_W] =
            hpc_pkg::ENV_W'((lub > dub) ? lub : dub);
      end
      return rom;
   endfunction

   localparam logic [TABLE_BITS-1:0] PULSE_ROM = build_rom();

   // Configuration registers
   logic [hpc_pkg::COLOR_W-1:0]     base_color_ff;
   logic [hpc_pkg::RATE_W-1:0]      beat_rate_ff;
   logic [hpc_pkg::FLOOR_W-1:0]     floor_level_ff;
   logic [hpc_pkg::RADIATE_W-1:0]   radiate_delay_ff;
   logic [hpc_pkg::LED_COUNT_W-1:0] led_count_ff;
   logic                            csr_write;
   hpc_pkg::reg_index_type          csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = hpc_pkg::reg_index_type'(csr_paddr[4:2]);

   // Write one register per access
   always_ff @(posedge clock) begin
      if (reset) begin
         base_color_ff    <= hpc_pkg::BASE_COLOR_RST;
         beat_rate_ff     <= hpc_pkg::BEAT_RATE_RST;
         floor_level_ff   <= hpc_pkg::FLOOR_LEVEL_RST;
         radiate_delay_ff <= hpc_pkg::RADIATE_DELAY_RST;
         led_count_ff     <= hpc_pkg::LED_COUNT_RST;
      end else if (csr_write) begin
         unique case (csr_index)
            hpc_pkg::REG_BASE_COLOR:    base_color_ff    <= csr_pwdata[23:0];
            hpc_pkg::REG_BEAT_RATE:     beat_rate_ff     <= csr_pwdata[15:0];
            hpc_pkg::REG_FLOOR_LEVEL:   floor_level_ff   <= csr_pwdata[8:0];
            hpc_pkg::REG_RADIATE_DELAY: radiate_delay_ff <= csr_pwdata[15:0];
            hpc_pkg::REG_LED_COUNT:     led_count_ff     <= csr_pwdata[10:0];
            default: ;
         endcase
      end
   end

   // Read back
   always_comb begin
      unique case (csr_index)
         hpc_pkg::REG_BASE_COLOR:    csr_prdata = 32'(base_color_ff);
         hpc_pkg::REG_BEAT_RATE:     csr_prdata = 32'(beat_rate_ff);
         hpc_pkg::REG_FLOOR_LEVEL:   csr_prdata = 32'(floor_level_ff);
         hpc_pkg::REG_RADIATE_DELAY: csr_prdata = 32'(radiate_delay_ff);
         hpc_pkg::REG_LED_COUNT:     csr_prdata = 32'(led_count_ff);
         default:                    csr_prdata = '0;
      endcase
   end

   // Pipeline advance: hold everything while the response slot is full and not taken
   logic rsp_valid_ff;
   logic adv;
   assign adv          = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = adv;

   // Entry stage: strip geometry and beat phase
   logic [hpc_pkg::LED_COUNT_W-1:0] n_eff, den_in;
   logic [hpc_pkg::NUM_W-1:0]       twice_idx, num_in;
   logic [33:0]                     beat_prod;
   hpc_pkg::div_stage_type          div_ff [hpc_pkg::DIV_STEPS+1];
   hpc_pkg::div_stage_type          div_in [hpc_pkg::DIV_STEPS+1];

   // Entry values, then the divider with one quotient bit per stage
   always_comb begin
      logic [hpc_pkg::NUM_W-1:0] r2;
      logic                      bit_q;
      if (led_count_ff == '0)          n_eff = hpc_pkg::LED_COUNT_W'(1);
      else if (led_count_ff > LED_CAP_C) n_eff = LED_CAP_C;
      else                             n_eff = led_count_ff;
      den_in    = n_eff - hpc_pkg::LED_COUNT_W'(1);
      twice_idx = {1'b0, req_ch.pixel_index, 1'b0};
      num_in    = (twice_idx >= {1'b0, den_in}) ? twice_idx - {1'b0, den_in}
                                                : {1'b0, den_in} - twice_idx;
      beat_prod = 34'(req_ch.time_ticks[17:0]) * 34'(beat_rate_ff);
      div_in[0].valid = req_ch.valid;
      div_in[0].rem   = num_in;
      div_in[0].quo   = '0;
      div_in[0].den   = den_in;
      div_in[0].zero  = (den_in == '0);
      div_in[0].sat   = num_in >= ({1'b0, den_in} << 1);
      div_in[0].beat  = beat_prod[17:2];
      for (int j = 1; j <= hpc_pkg::DIV_STEPS; j++) begin
         r2 = (j == 1) ? div_ff[j-1].rem : (div_ff[j-1].rem << 1);
         bit_q = r2 >= {1'b0, div_ff[j-1].den};
         div_in[j]      = div_ff[j-1];
         div_in[j].rem  = bit_q ? r2 - {1'b0, div_ff[j-1].den} : r2;
         div_in[j].quo  = {div_ff[j-1].quo[hpc_pkg::DIV_STEPS-2:0], bit_q};
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j <= hpc_pkg::DIV_STEPS; j++) begin
         if (reset) begin
            div_ff[j].valid <= 1'b0;
         end else if (adv) begin
            div_ff[j] <= div_in[j];
         end
      end
   end

   // Distance, saturated at one
   logic [hpc_pkg::DIST_W-1:0] distance;
   localparam logic [hpc_pkg::DIST_W-1:0] DIST_ONE = 17'h10000;
   always_comb begin
      priority if (div_ff[hpc_pkg::DIV_STEPS].zero) distance = '0;
      else if (div_ff[hpc_pkg::DIV_STEPS].sat)      distance = DIST_ONE;
      else if (div_ff[hpc_pkg::DIV_STEPS].quo > DIST_ONE) distance = DIST_ONE;
      else distance = div_ff[hpc_pkg::DIV_STEPS].quo;
   end

   // Delay multiply stage
   logic                        m_valid_ff;
   logic [32:0]                 m_delay_ff;
   logic [hpc_pkg::PHASE_W-1:0] m_beat_ff;
   logic [hpc_pkg::DIST_W-1:0]  m_dist_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
      end else if (adv) begin
         m_valid_ff <= div_ff[hpc_pkg::DIV_STEPS].valid;
      end
      if (adv) begin
         m_delay_ff <= 33'(distance) * 33'(radiate_delay_ff);
         m_beat_ff  <= div_ff[hpc_pkg::DIV_STEPS].beat;
         m_dist_ff  <= distance;
      end
   end

   // Phase and table index stage
   logic [hpc_pkg::PHASE_W-1:0]  phase;
   logic [hpc_pkg::PHASE_W+KW:0] k_prod;
   logic                         k_valid_ff;
   logic [KW-1:0]                k_ff;

   assign phase  = m_beat_ff - m_delay_ff[31:16];
   assign k_prod = (hpc_pkg::PHASE_W+KW+1)'(phase) * (hpc_pkg::PHASE_W+KW+1)'(DEPTH_C);

   always_ff @(posedge clock) begin
      if (reset) begin
         k_valid_ff <= 1'b0;
      end else if (adv) begin
         k_valid_ff <= m_valid_ff;
      end
      if (adv) begin
         k_ff <= k_prod[hpc_pkg::PHASE_W+KW-1:hpc_pkg::PHASE_W];
      end
   end

   // Pulse table read
   logic                      t_valid_ff;
   logic [hpc_pkg::ENV_W-1:0] t_env_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         t_valid_ff <= 1'b0;
      end else if (adv) begin
         t_valid_ff <= k_valid_ff;
      end
      if (adv) begin
         t_env_ff <= PULSE_ROM[k_ff*hpc_pkg::ENV_W +: hpc_pkg::ENV_W];
      end
   end

   // Brightness level stage
   logic [hpc_pkg::FLOOR_W-1:0] fl;
   logic [25:0]                 lift;
   logic [17:0]                 level_sum;
   logic                        l_valid_ff;
   logic [16:0]                 l_level_ff;

   assign fl        = (floor_level_ff > hpc_pkg::FULL_SCALE) ? hpc_pkg::FULL_SCALE
                                                             : floor_level_ff;
   assign lift      = 26'(hpc_pkg::FULL_SCALE - fl) * 26'(t_env_ff);
   assign level_sum = {1'b0, fl, 8'd0} + 18'(lift[25:8]);

   always_ff @(posedge clock) begin
      if (reset) begin
         l_valid_ff <= 1'b0;
      end else if (adv) begin
         l_valid_ff <= t_valid_ff;
      end
      if (adv) begin
         l_level_ff <= level_sum[16:0];
      end
   end

   // Color scale stage and response register
   logic [24:0]                 red_prod, green_prod, blue_prod;
   logic [hpc_pkg::CHAN_W-1:0]  red_ff, green_ff, blue_ff;

   assign red_prod   = 25'(base_color_ff[23:16]) * 25'(l_level_ff);
   assign green_prod = 25'(base_color_ff[15:8])  * 25'(l_level_ff);
   assign blue_prod  = 25'(base_color_ff[7:0])   * 25'(l_level_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= l_valid_ff;
      end
      if (adv) begin
         red_ff   <= red_prod[23:16];
         green_ff <= green_prod[23:16];
         blue_ff  <= blue_prod[23:16];
      end
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.red   = red_ff;
   assign rsp_ch.green = green_ff;
   assign rsp_ch.blue  = blue_ff;

   // Checks
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> div_ff[0].valid)
      else $error("accepted request did not enter the pipeline");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(m_valid_ff) && $stable(k_valid_ff) && $stable(t_valid_ff)
               && $stable(l_valid_ff))
      else $error("pipeline moved during a stall");

   a_dist_range: assert property (@(posedge clock) disable iff (reset)
      m_valid_ff |-> m_dist_ff <= DIST_ONE)
      else $error("distance above one");

   a_level_range: assert property (@(posedge clock) disable iff (reset)
      l_valid_ff |-> l_level_ff <= 17'h10000)
      else $error("level above full scale");

endmodule

### test/heartbeat_pixel_color_top_tb.sv
// Testbench for the heartbeat pixel color pipeline: directed and random requests, self-checking.
`timescale 1ns / 100ps

module heartbeat_pixel_color_top_tb;

   typedef struct packed {
      logic [hpc_pkg::PIXEL_W-1:0] pixel_index;
      logic [hpc_pkg::TIME_W-1:0]  time_ticks;
   } pixel_req_type;

   typedef struct packed {
      logic [hpc_pkg::CHAN_W-1:0] red;
      logic [hpc_pkg::CHAN_W-1:0] green;
      logic [hpc_pkg::CHAN_W-1:0] blue;
   } rgb_type;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 60;
   localparam int HOLD_CYCLES    = 200;

   logic clock;
   logic reset;
   logic csr_psel, csr_penable, csr_pwrite;
   logic [hpc_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [hpc_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [hpc_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   hpc_req_if req_ch ();
   hpc_rsp_if rsp_ch ();

   heartbeat_pixel_color_top dut (
      .clock(clock), .reset(reset), .req_ch(req_ch.sink), .rsp_ch(rsp_ch.source),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   // Predictor copy of the registers
   logic [hpc_pkg::COLOR_W-1:0]     cur_color;
   logic [hpc_pkg::RATE_W-1:0]      cur_rate;
   logic [hpc_pkg::FLOOR_W-1:0]     cur_floor;
   logic [hpc_pkg::RADIATE_W-1:0]   cur_radiate;
   logic [hpc_pkg::LED_COUNT_W-1:0] cur_leds;

   pixel_req_type pending_reqs[$];
   rgb_type       expected_rgb[$];
   int  error_count = 0;
   int  idle_cycles = 0;
   bit  hold_rsp = 0;
   int  hold_count = 0;
   int  send_wait = 0;
   int  take_wait = 0;
   bit  req_taken = 0;
   bit  rsp_taken = 0;

   always begin
      clock = 1'b1; #1;
      clock = 1'b0; #1;
   end

   // exp(-u) for u in Q16, result in Q16
   function automatic longint unsigned exp_neg_q16(longint unsigned u);
      longint unsigned v, v2, v3, e;
      if (u >= (64'd20 << 16)) return 0;
      v  = u << 6;
      v2 = (v * v) >> 30;
      v3 = (v2 * v) >> 30;
      e  = hpc_pkg::ONE_Q30 - v + (v2 >> 1) - v3 / 6;
      for (int k = 0; k < 8; k++) e = (e * e) >> 30;
      return e >> 14;
   endfunction

   function automatic longint unsigned pulse_bump(longint unsigned p, longint unsigned ctr,
                                                  longint unsigned den);
      longint unsigned d;
      d = (p - ctr) & 64'hFFFF;
      if (d > 32768) d = 65536 - d;
      return exp_neg_q16(((d * d) << 16) / den);
   endfunction

   function automatic rgb_type pixel_color(pixel_req_type r);
      longint unsigned n, den, num, distance, beat, delay, phase, k, p, lub, dub, env, fl;
      longint unsigned level;
      rgb_type c;
      n = 64'(cur_leds);
      if (n < 1) n = 1;
      if (n > 1024) n = 1024;
      den = n - 1;
      if (den == 0) distance = 0;
      else begin
         num  = (2 * r.pixel_index >= den) ? 2 * r.pixel_index - den : den - 2 * r.pixel_index;
         distance = (num << 16) / den;
         if (distance > 65536) distance = 65536;
      end
      beat  = ((longint'(r.time_ticks) * cur_rate) >> 2) & 64'hFFFF;
      delay = (distance * cur_radiate) >> 16;
      phase = (beat - delay) & 64'hFFFF;
      k   = (phase * 256) >> 16;
      p   = (k * 65536) / 256;
      lub = pulse_bump(p, hpc_pkg::LUB_CENTER, hpc_pkg::LUB_DEN);
      dub = (pulse_bump(p, hpc_pkg::DUB_CENTER, hpc_pkg::DUB_DEN) * hpc_pkg::DUB_SCALE) >> 16;
      env = lub > dub ? lub : dub;
      fl  = cur_floor > 256 ? 256 : 64'(cur_floor);
      level = fl * 256 + (((256 - fl) * env) >> 8);
      c.red   = 8'((cur_color[23:16] * level) >> 16);
      c.green = 8'((cur_color[15:8] * level) >> 16);
      c.blue  = 8'((cur_color[7:0] * level) >> 16);
      return c;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("rgb %s: got %0d, want %0d", what, got, want);
      error_count++;
   endtask

   // Register write over APB, setup then access
   task automatic csr_write(hpc_pkg::reg_index_type idx, logic [31:0] value);
      @(negedge clock);
      csr_psel = 1; csr_penable = 0; csr_pwrite = 1;
      csr_paddr = hpc_pkg::CSR_ADDR_W'(4 * idx); csr_pwdata = value;
      @(negedge clock);
      csr_penable = 1;
      @(negedge clock);
      csr_psel = 0; csr_penable = 0; csr_pwrite = 0;
      case (idx)
         hpc_pkg::REG_BASE_COLOR:    cur_color   = value[23:0];
         hpc_pkg::REG_BEAT_RATE:     cur_rate    = value[15:0];
         hpc_pkg::REG_FLOOR_LEVEL:   cur_floor   = value[8:0];
         hpc_pkg::REG_RADIATE_DELAY: cur_radiate = value[15:0];
         hpc_pkg::REG_LED_COUNT:     cur_leds    = value[10:0];
         default: ;
      endcase
   endtask

   task automatic wait_drained();
      while (pending_reqs.size() != 0 || req_ch.valid || expected_rgb.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic add_req(logic [hpc_pkg::PIXEL_W-1:0] px, logic [hpc_pkg::TIME_W-1:0] t);
      pixel_req_type r;
      r.pixel_index = px; r.time_ticks = t;
      pending_reqs.push_back(r);
   endtask

   // Driver: present requests at the falling edge with random gaps
   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid <= 0;
      end else if (req_ch.valid && !req_taken) begin
         // hold the request
      end else if (send_wait > 0) begin
         send_wait <= send_wait - 1;
         req_ch.valid <= 0;
      end else if (pending_reqs.size() != 0) begin
         req_ch.valid <= 1;
         {req_ch.pixel_index, req_ch.time_ticks} <= pending_reqs.pop_front();
         send_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
      end else begin
         req_ch.valid <= 0;
      end
   end

   // Predict at acceptance
   always @(posedge clock) begin
      req_taken <= !reset && req_ch.valid && req_ch.ready;
      if (!reset && req_ch.valid && req_ch.ready)
         expected_rgb.push_back(pixel_color({req_ch.pixel_index, req_ch.time_ticks}));
   end

   // Response side readiness
   always @(negedge clock) begin
      int w;
      if (reset) begin
         rsp_ch.ready <= 0;
      end else if (hold_rsp && hold_count < HOLD_CYCLES) begin
         hold_count <= hold_count + 1;
         rsp_ch.ready <= 0;
      end else if (rsp_taken) begin
         w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
         take_wait <= (w == 0) ? 0 : w - 1;
         rsp_ch.ready <= (w == 0);
      end else if (take_wait > 0) begin
         take_wait <= take_wait - 1;
         rsp_ch.ready <= 0;
      end else begin
         rsp_ch.ready <= 1;
      end
   end

   // Monitor: compare each response with the oldest expectation
   always @(posedge clock) begin
      rgb_type want;
      rsp_taken <= !reset && rsp_ch.valid && rsp_ch.ready;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_rgb.size() == 0) begin
            $display("rgb response with nothing expected");
            error_count++;
         end else begin
            want = expected_rgb.pop_front();
            if (rsp_ch.red != want.red)     report_mismatch("red", rsp_ch.red, want.red);
            if (rsp_ch.green != want.green) report_mismatch("green", rsp_ch.green, want.green);
            if (rsp_ch.blue != want.blue)   report_mismatch("blue", rsp_ch.blue, want.blue);
         end
      end
   end

   // Watchdog on cycles without any handshake
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || reset)
         idle_cycles <= 0;
      else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("heartbeat_pixel_color_top: mismatch");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   task automatic random_phase(int count, int max_px);
      for (int i = 0; i < count; i++)
         add_req(hpc_pkg::PIXEL_W'($urandom_range(0, max_px)), $urandom());
   endtask

   initial begin
      logic [31:0] v;
      reset = 1;
      csr_psel = 0; csr_penable = 0; csr_pwrite = 0; csr_paddr = '0; csr_pwdata = '0;
      req_ch.valid = 0; req_ch.pixel_index = '0; req_ch.time_ticks = '0;
      rsp_ch.ready = 0;
      cur_color = hpc_pkg::BASE_COLOR_RST; cur_rate = hpc_pkg::BEAT_RATE_RST;
      cur_floor = hpc_pkg::FLOOR_LEVEL_RST;
      cur_radiate = hpc_pkg::RADIATE_DELAY_RST; cur_leds = hpc_pkg::LED_COUNT_RST;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // Directed: field extremes, center and strip ends at reset settings
      add_req(0, 0); add_req(1023, 32'hFFFFFFFF); add_req(511, 0); add_req(512, 100);
      add_req(0, 32'hFFFFFFFF); add_req(1023, 0); add_req(512, 32'h5555AAAA);
      add_req(10'h2AA, 32'hAAAA5555); add_req(10'h155, 32'h12345678);
      wait_drained();

      // Short strip with pixels beyond it, floor above full scale, white
      csr_write(hpc_pkg::REG_LED_COUNT, 10);
      csr_write(hpc_pkg::REG_FLOOR_LEVEL, 511);
      csr_write(hpc_pkg::REG_BASE_COLOR, 24'hFFFFFF);
      add_req(0, 7); add_req(9, 7); add_req(10, 7); add_req(1023, 7);
      wait_drained();

      // Zero led count, single pixel, zero floor, max rate and radiate
      csr_write(hpc_pkg::REG_LED_COUNT, 0);
      csr_write(hpc_pkg::REG_FLOOR_LEVEL, 0);
      csr_write(hpc_pkg::REG_BEAT_RATE, 16'hFFFF);
      csr_write(hpc_pkg::REG_RADIATE_DELAY, 16'hFFFF);
      add_req(0, 1); add_req(5, 300); add_req(1023, 32'hFFFFFFFF);
      wait_drained();
      csr_write(hpc_pkg::REG_LED_COUNT, 1); // same effective value as zero
      add_req(0, 40);
      wait_drained();
      csr_write(hpc_pkg::REG_LED_COUNT, 2047);
      csr_write(hpc_pkg::REG_BEAT_RATE, 0);
      csr_write(hpc_pkg::REG_RADIATE_DELAY, 0);
      add_req(0, 9); add_req(1023, 9);
      wait_drained();

      // Pressure: hold the response side while requests keep coming
      csr_write(hpc_pkg::REG_BEAT_RATE, 512);
      csr_write(hpc_pkg::REG_FLOOR_LEVEL, 256);
      hold_rsp = 1;
      random_phase(60, 1023);
      wait (hold_count == HOLD_CYCLES);
      hold_rsp = 0;
      wait_drained();

      // Random phases over random register settings
      for (int ph = 0; ph < 12; ph++) begin
         v = $urandom();
         csr_write(hpc_pkg::REG_BASE_COLOR, v & 32'hFFFFFF);
         csr_write(hpc_pkg::REG_BEAT_RATE,
                   $urandom_range(0, 3) == 0 ? 16'hFFFF : $urandom() & 16'hFFFF);
         csr_write(hpc_pkg::REG_FLOOR_LEVEL,
                   $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 511));
         csr_write(hpc_pkg::REG_RADIATE_DELAY, $urandom() & 16'hFFFF);
         csr_write(hpc_pkg::REG_LED_COUNT,
                   ph % 4 == 0 ? $urandom_range(0, 2047) : $urandom_range(1, 1024));
         random_phase(160, ph % 3 == 0 ? 1023 : (cur_leds == 0 ? 0 : int'(cur_leds) - 1) % 1024);
         wait_drained();
      end

      if (error_count == 0)
         $display("heartbeat_pixel_color_top: match");
      else
         $display("heartbeat_pixel_color_top: mismatch");
      $finish;
   end

endmodule
